// ----- hw/rtl/yaw_pitch_camera_update_macros.svh -----
// assertion macros for the yaw/pitch camera block
// no dependencies; define ASSERT_OFF to drop all assertions
`ifndef YAW_PITCH_CAMERA_UPDATE_MACROS_SVH
`define YAW_PITCH_CAMERA_UPDATE_MACROS_SVH
`ifndef ASSERT_OFF
`define YPC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define YPC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define YPC_ASSERT(lbl, clk, rst_n, prop)
`define YPC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- hw/rtl/ypc_pkg.sv -----
// shared types and constants for the yaw/pitch camera block
// no dependencies
package ypc_pkg;

  localparam int unsigned CordicSteps = 28;
  localparam int unsigned StepW = 5;

  localparam logic [1:0] ModeRotate    = 2'd0;
  localparam logic [1:0] ModeMove      = 2'd1;
  localparam logic [1:0] ModeTranslate = 2'd2;
  localparam logic [1:0] ModeReport    = 2'd3;

  localparam logic [1:0] CfgGain  = 2'd0;
  localparam logic [1:0] CfgStep  = 2'd1;
  localparam logic [1:0] CfgSight = 2'd2;

  localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;

  // datapath operations driven by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // clear move deltas, update angles, translate
    OP_CORDIC_Y,  // set up cordic on yaw
    OP_ITER,      // one cordic step
    OP_SAVE_Y,    // store yaw sin/cos, set up cordic on pitch
    OP_SAVE_P,    // store pitch sin/cos
    OP_MUL,       // one multiply step on the shared multiplier, index from controller
    OP_OUT        // load output register
  } ypc_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_CY, ST_ITY, ST_SY, ST_ITP, ST_SP, ST_MUL, ST_OUT, ST_WAIT
  } ypc_state_e;

  typedef struct packed {
    ypc_op_e          op;
    logic [StepW-1:0] idx;
  } ypc_cmd_t;

  typedef struct packed {
    logic is_rotate;
    logic out_busy;
  } ypc_sts_t;

  function automatic logic signed [31:0] atan_turn(input logic [StepW-1:0] i);
    case (i)
      5'd0: return 32'sd536870912;  5'd1: return 32'sd316933406;
      5'd2: return 32'sd167458907;  5'd3: return 32'sd85004756;
      5'd4: return 32'sd42667331;   5'd5: return 32'sd21354465;
      5'd6: return 32'sd10679838;   5'd7: return 32'sd5340245;
      5'd8: return 32'sd2670163;    5'd9: return 32'sd1335087;
      5'd10: return 32'sd667544;    5'd11: return 32'sd333772;
      5'd12: return 32'sd166886;    5'd13: return 32'sd83443;
      5'd14: return 32'sd41722;     5'd15: return 32'sd20861;
      5'd16: return 32'sd10430;     5'd17: return 32'sd5215;
      5'd18: return 32'sd2608;      5'd19: return 32'sd1304;
      5'd20: return 32'sd652;       5'd21: return 32'sd326;
      5'd22: return 32'sd163;       5'd23: return 32'sd81;
      5'd24: return 32'sd41;        5'd25: return 32'sd20;
      5'd26: return 32'sd10;        5'd27: return 32'sd5;
      default: return 32'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [17:0] clamp_unit(input logic signed [33:0] v);
    if (v > 34'sd65536) return 18'sd65536;
    if (v < -34'sd65536) return -18'sd65536;
    return v[17:0];
  endfunction

endpackage

// ----- hw/rtl/ypc_ctrl.sv -----
// controller state machine for the yaw/pitch camera block
// depends on ypc_pkg
module ypc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  ypc_pkg::ypc_sts_t sts_i,
  output ypc_pkg::ypc_cmd_t cmd_o,
  output logic              busy_o
);
  import ypc_pkg::*;

  ypc_state_e       state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: if (in_fire_i) state_d = ST_LOAD;
      ST_LOAD: begin
        cnt_d   = '0;
        state_d = sts_i.is_rotate ? ST_CY : ST_MUL;
      end
      ST_CY:  begin cnt_d = '0; state_d = ST_ITY; end
      ST_ITY: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StepW'(CordicSteps - 1)) state_d = ST_SY;
      end
      ST_SY:  begin cnt_d = '0; state_d = ST_ITP; end
      ST_ITP: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StepW'(CordicSteps - 1)) state_d = ST_SP;
      end
      ST_SP:  begin cnt_d = '0; state_d = ST_MUL; end
      // steps 0..3: view/up products, 4: copy pitch sin/cos, 6..8: move deltas, 9..11: look offsets
      ST_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StepW'(11)) state_d = ST_WAIT;
      end
      ST_WAIT: if (!sts_i.out_busy) state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o.op  = OP_NONE;
    cmd_o.idx = cnt_q;
    busy_o    = (state_q != ST_IDLE);
    case (state_q)
      ST_LOAD: cmd_o.op = OP_LOAD;
      ST_CY:   cmd_o.op = OP_CORDIC_Y;
      ST_ITY:  cmd_o.op = OP_ITER;
      ST_SY:   cmd_o.op = OP_SAVE_Y;
      ST_ITP:  cmd_o.op = OP_ITER;
      ST_SP:   cmd_o.op = OP_SAVE_P;
      ST_MUL:  cmd_o.op = OP_MUL;
      ST_OUT:  cmd_o.op = OP_OUT;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `include "yaw_pitch_camera_update_macros.svh"
  `YPC_ASSERT(a_accept_idle, clk_i, rst_ni, in_fire_i |-> state_q == ST_IDLE)
  `YPC_ASSERT(a_load_next, clk_i, rst_ni, in_fire_i |=> state_q == ST_LOAD)
  `YPC_ASSERT(a_cnt_range, clk_i, rst_ni, state_q == ST_MUL |-> cnt_q <= StepW'(11))
endmodule

// ----- hw/rtl/ypc_datapath.sv -----
// datapath: angles, shared cordic, shared multiplier, eye/view/up state
// depends on ypc_pkg
module ypc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ypc_pkg::ypc_cmd_t cmd_i,
  output ypc_pkg::ypc_sts_t sts_o,
  input  logic              in_fire_i,
  input  logic [55:0]       in_data_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [247:0]      out_data_o
);
  import ypc_pkg::*;

  logic [31:0] gain_q;
  logic [30:0] step_q, sight_q;
  logic [55:0] item_q;
  logic [31:0] yaw_q, pitch_q;
  logic signed [31:0] eye_q [3];
  logic signed [17:0] view_q [3];
  logic signed [17:0] up_q [3];
  logic signed [17:0] sy_q, cy_q, sp_q, cp_q;
  logic signed [31:0] dlt_q [3];
  logic signed [31:0] look_q [3];
  logic signed [33:0] cx_q, cyv_q, cz_q;
  logic [1:0] quad_q;
  logic out_valid_q;
  logic [247:0] out_q;

  logic [1:0] f_mode, f_axis;
  logic signed [1:0] f_sgn;
  logic [11:0] f_ox, f_oy, f_nx, f_ny;
  assign f_mode = item_q[1:0];
  assign f_ox = item_q[13:2];
  assign f_oy = item_q[25:14];
  assign f_nx = item_q[37:26];
  assign f_ny = item_q[49:38];
  assign f_sgn = item_q[51:50];
  assign f_axis = item_q[53:52];

  assign sts_o.is_rotate = (f_mode == ModeRotate);
  assign sts_o.out_busy  = out_valid_q;

  // cordic setup for one angle
  function automatic logic [33:0] red_z(input logic [31:0] a);
    logic [1:0] q;
    logic [31:0] d;
    q = 2'((a + 32'h2000_0000) >> 30);
    d = a - {q, 30'd0};
    return {{2{d[31]}}, d};
  endfunction

  logic [31:0] cord_ang;
  logic [1:0]  cord_q;
  assign cord_ang = (cmd_i.op == OP_CORDIC_Y) ? yaw_q : pitch_q;
  assign cord_q   = 2'((cord_ang + 32'h2000_0000) >> 30);

  // one cordic step
  logic signed [33:0] dx, dy, at;
  assign dx = cyv_q >>> cmd_i.idx;
  assign dy = cx_q >>> cmd_i.idx;
  assign at = 34'(atan_turn(cmd_i.idx));

  // rounded sin/cos with quadrant fixup
  logic signed [17:0] c_r, s_r, sn_f, cs_f;
  assign c_r = clamp_unit((cx_q + 34'sd8192) >>> 14);
  assign s_r = clamp_unit((cyv_q + 34'sd8192) >>> 14);
  always_comb begin
    case (quad_q)
      2'd0: begin cs_f = c_r;  sn_f = s_r;  end
      2'd1: begin cs_f = -s_r; sn_f = c_r;  end
      2'd2: begin cs_f = -c_r; sn_f = -s_r; end
      default: begin cs_f = s_r; sn_f = -c_r; end
    endcase
  end

  // shared multiplier operand selection
  logic signed [31:0] ma;
  logic signed [17:0] mb;
  always_comb begin
    ma = '0; mb = '0;
    case (cmd_i.idx)
      5'd0: begin ma = 32'(sy_q); mb = cp_q; end
      5'd1: begin ma = 32'(cy_q); mb = cp_q; end
      5'd2: begin ma = 32'(sy_q); mb = sp_q; end
      5'd3: begin ma = 32'(sp_q); mb = cy_q; end
      5'd4, 5'd5: begin ma = '0; mb = '0; end
      5'd6, 5'd7, 5'd8: begin
        ma = $signed({1'b0, step_q}); mb = view_q[2'(cmd_i.idx - 5'd6)];
      end
      5'd9, 5'd10, 5'd11: begin
        ma = $signed({1'b0, sight_q}); mb = view_q[2'(cmd_i.idx - 5'd9)];
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  logic signed [49:0] prod;
  logic signed [33:0] pr;
  assign prod = ma * mb;
  assign pr   = 34'((prod + 50'sd32768) >>> 16);

  logic [31:0] dyaw, dpitch;
  assign dyaw   = gain_q * 32'($signed({1'b0, f_ox}) - $signed({1'b0, f_nx}));
  assign dpitch = gain_q * 32'($signed({1'b0, f_oy}) - $signed({1'b0, f_ny}));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= '0;
      step_q  <= '0;
      sight_q <= 31'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgGain:  gain_q  <= cfg_data_i;
        CfgStep:  step_q  <= cfg_data_i[30:0];
        CfgSight: sight_q <= cfg_data_i[30:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) item_q <= in_data_i;
  end

  // camera state and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q <= '0; pitch_q <= '0;
      eye_q[0] <= 32'sd0; eye_q[1] <= 32'sd104858; eye_q[2] <= 32'sd65536;
      view_q[0] <= '0; view_q[1] <= '0; view_q[2] <= -18'sd65536;
      up_q[0] <= '0; up_q[1] <= 18'sd65536; up_q[2] <= '0;
      sy_q <= '0; cy_q <= '0; sp_q <= '0; cp_q <= '0;
      cx_q <= '0; cyv_q <= '0; cz_q <= '0; quad_q <= '0;
      for (int k = 0; k < 3; k++) begin dlt_q[k] <= '0; look_q[k] <= '0; end
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          for (int k = 0; k < 3; k++) dlt_q[k] <= '0;
          if (f_mode == ModeRotate) begin
            yaw_q   <= yaw_q + dyaw;
            pitch_q <= pitch_q - dpitch;
          end else if (f_mode == ModeTranslate && f_axis != 2'd3) begin
            eye_q[f_axis] <= sat32(36'(eye_q[f_axis]) +
                                   36'(f_sgn) * $signed({5'd0, step_q}));
          end
        end
        OP_CORDIC_Y, OP_SAVE_Y: begin
          if (cmd_i.op == OP_SAVE_Y) begin sy_q <= sn_f; cy_q <= cs_f; end
          quad_q <= cord_q;
          cx_q   <= CordicGainQ30;
          cyv_q  <= '0;
          cz_q   <= red_z(cord_ang);
        end
        OP_ITER: begin
          if (!cz_q[33]) begin
            cx_q <= cx_q - dx; cyv_q <= cyv_q + dy; cz_q <= cz_q - at;
          end else begin
            cx_q <= cx_q + dx; cyv_q <= cyv_q - dy; cz_q <= cz_q + at;
          end
        end
        OP_SAVE_P: begin sp_q <= sn_f; cp_q <= cs_f; end
        OP_MUL: begin
          case (cmd_i.idx)
            5'd0: if (f_mode == ModeRotate) view_q[0] <= pr[17:0];
            5'd1: if (f_mode == ModeRotate) view_q[2] <= -pr[17:0];
            5'd2: if (f_mode == ModeRotate) up_q[0] <= -pr[17:0];
            5'd3: if (f_mode == ModeRotate) up_q[2] <= pr[17:0];
            5'd4: if (f_mode == ModeRotate) begin view_q[1] <= sp_q; up_q[1] <= cp_q; end
            5'd6, 5'd7, 5'd8: dlt_q[2'(cmd_i.idx - 5'd6)] <= pr[31:0];
            5'd9, 5'd10, 5'd11: begin
              look_q[2'(cmd_i.idx - 5'd9)] <= pr[31:0];
              // apply move once all deltas are known
              if (cmd_i.idx == 5'd9 && f_mode == ModeMove)
                for (int k = 0; k < 3; k++)
                  eye_q[k] <= sat32(36'(eye_q[k]) + 36'(f_sgn) * 36'(dlt_q[k]));
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // output register
  logic signed [31:0] lk [3];
  always_comb begin
    for (int k = 0; k < 3; k++) lk[k] = sat32(36'(eye_q[k]) + 36'(look_q[k]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_OUT)
      out_q <= {2'b00, up_q[2], up_q[1], up_q[0], lk[2], lk[1], lk[0],
                eye_q[2], eye_q[1], eye_q[0]};
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `include "yaw_pitch_camera_update_macros.svh"
  `YPC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_q && !out_ready_i |=> out_valid_q)
  `YPC_ASSERT(a_no_overwrite, clk_i, rst_ni, cmd_i.op == OP_OUT |-> !out_valid_q)
  `YPC_ASSERT(a_view_unit, clk_i, rst_ni,
    view_q[1] <= 18'sd65536 && view_q[1] >= -18'sd65536)
endmodule

// ----- hw/rtl/yaw_pitch_camera_update.sv -----
// yaw/pitch fly camera: one result per item, sequential controller and datapath
// rotate runs two 28-step cordic passes on one shared unit before the multiply steps;
// every mode then takes 12 steps on one shared 32x18 multiplier
// one item in flight; next item accepted the cycle after the result is registered,
// and a new result waits until the previous one has been taken
// reset: asynchronous active low, eye (0,1.6,1), view (0,0,-1), up (0,1,0)
module yaw_pitch_camera_update (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mode, old_x, old_y, new_x, new_y, step_sign, axis (low bit first), zero pad
  input  logic [55:0]  s_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // eye_x, eye_y, eye_z, look_x, look_y, look_z, up_x, up_y, up_z, zero pad
  output logic [247:0] m_axis_tdata
);
  import ypc_pkg::*;

  ypc_cmd_t cmd;
  ypc_sts_t sts;
  logic     busy;
  logic     fire;

  assign s_axis_tready = !busy;
  assign fire = s_axis_tvalid && !busy;

  ypc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(fire), .sts_i(sts), .cmd_o(cmd), .busy_o(busy)
  );

  ypc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .in_fire_i(fire),
    .in_data_i(s_axis_tdata), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(m_axis_tdata)
  );
endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the yaw/pitch fly camera block
// depends on ypc_pkg and yaw_pitch_camera_update; predicts every result beat in a scoreboard class
module tb_top;
  import ypc_pkg::*;

  // camera predictor and store of expected result beats
  class camera_scoreboard;
    bit [31:0] gain;
    bit [30:0] step_len;
    bit [30:0] sight_len;
    bit [31:0] yaw;
    bit [31:0] pitch;
    longint eye[3];
    longint view[3];
    longint up[3];
    longint arc[28];
    bit [245:0] pending_views[$];
    int errors;
    int checked;
    int op_count[4];

    function new();
      arc = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
              10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
              41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
      gain = 0;
      step_len = 0;
      sight_len = 31'd65536;
      yaw = 0;
      pitch = 0;
      eye = '{0, 104858, 65536};
      view = '{0, 0, -65536};
      up = '{0, 65536, 0};
      errors = 0;
      checked = 0;
      op_count = '{0, 0, 0, 0};
    endfunction

    function void write_reg(logic [1:0] idx, bit [31:0] val);
      case (idx)
        CfgGain:  gain = val;
        CfgStep:  step_len = val[30:0];
        CfgSight: sight_len = val[30:0];
        default: ;
      endcase
    endfunction

    function longint sat_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint clamp_one(longint v);
      if (v > 65536) return 65536;
      if (v < -65536) return -65536;
      return v;
    endfunction

    // q16.16 product, rounded half up
    function longint qmul(longint a, longint b);
      return (a * b + 32768) >>> 16;
    endfunction

    // cordic on the angle folded into [-45, 45) degrees, then quadrant fix-up
    function void sin_cos(bit [31:0] ang, output longint sn, output longint cs);
      bit [31:0] quad;
      bit [31:0] rem;
      longint z, x, y, dx, dy, c, s;
      quad = (ang + 32'h2000_0000) >> 30;
      rem = ang - (quad << 30);
      z = longint'($signed(rem));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 28; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= arc[i];
        end else begin
          x += dx; y -= dy; z += arc[i];
        end
      end
      c = clamp_one((x + 8192) >>> 14);
      s = clamp_one((y + 8192) >>> 14);
      case (quad[1:0])
        2'd0: begin cs = c;  sn = s;  end
        2'd1: begin cs = -s; sn = c;  end
        2'd2: begin cs = -c; sn = -s; end
        default: begin cs = s; sn = -c; end
      endcase
    endfunction

    // apply one accepted input beat and queue the result it must produce
    function void note_item(bit [55:0] beat);
      logic [1:0] mode;
      bit [31:0] ox, oy, nx, ny;
      longint sgn, sy, cy, sp, cp, look;
      bit [1:0] ax;
      bit [245:0] view_beat;
      mode = beat[1:0];
      ox = beat[13:2];
      oy = beat[25:14];
      nx = beat[37:26];
      ny = beat[49:38];
      sgn = longint'($signed(beat[51:50]));
      ax = beat[53:52];
      op_count[mode]++;
      if (mode == ModeRotate) begin
        yaw = yaw + gain * (ox - nx);
        pitch = pitch - gain * (oy - ny);
        sin_cos(yaw, sy, cy);
        sin_cos(pitch, sp, cp);
        view[0] = qmul(sy, cp);
        view[1] = sp;
        view[2] = -qmul(cy, cp);
        up[0] = -qmul(sy, sp);
        up[1] = cp;
        up[2] = qmul(sp, cy);
      end else if (mode == ModeMove) begin
        for (int k = 0; k < 3; k++)
          eye[k] = sat_word(eye[k] + sgn * qmul(longint'(step_len), view[k]));
      end else if (mode == ModeTranslate) begin
        if (ax != 2'd3)
          eye[ax] = sat_word(eye[ax] + sgn * longint'(step_len));
      end
      for (int k = 0; k < 3; k++) begin
        look = sat_word(eye[k] + qmul(longint'(sight_len), view[k]));
        view_beat[32*k +: 32] = eye[k][31:0];
        view_beat[96 + 32*k +: 32] = look[31:0];
        view_beat[192 + 18*k +: 18] = up[k][17:0];
      end
      pending_views.push_back(view_beat);
    endfunction

    // compare one accepted result beat with the oldest expectation
    function void check_result(bit [247:0] got);
      bit [245:0] want;
      string names[9] = '{"eye_x", "eye_y", "eye_z", "look_x", "look_y", "look_z",
                          "up_x", "up_y", "up_z"};
      checked++;
      if (pending_views.size() == 0) begin
        errors++;
        $display("%0t: result beat with no expectation: %h", $time, got);
        return;
      end
      want = pending_views.pop_front();
      for (int k = 0; k < 6; k++)
        if (got[32*k +: 32] !== want[32*k +: 32]) begin
          errors++;
          $display("%0t: %s expected %h actual %h", $time, names[k],
                   want[32*k +: 32], got[32*k +: 32]);
        end
      for (int k = 0; k < 3; k++)
        if (got[192 + 18*k +: 18] !== want[192 + 18*k +: 18]) begin
          errors++;
          $display("%0t: %s expected %h actual %h", $time, names[6+k],
                   want[192 + 18*k +: 18], got[192 + 18*k +: 18]);
        end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata;
  logic         cfg_we_i;
  logic [1:0]   cfg_idx_i;
  logic [31:0]  cfg_data_i;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [247:0] m_axis_tdata;

  camera_scoreboard sb = new();
  bit calm;
  int hold_cycles;

  yaw_pitch_camera_update dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  // result side: random stalls, long hold-off on request, check at the rising edge
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 23);
      end
    end
  end

  function automatic logic [55:0] pack_item(logic [1:0] mode, bit [11:0] ox, bit [11:0] oy,
                                            bit [11:0] nx, bit [11:0] ny, bit [1:0] sgn,
                                            bit [1:0] ax);
    return {2'b00, ax, sgn, ny, nx, oy, ox, mode};
  endfunction

  task automatic write_reg(logic [1:0] idx, bit [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // offer one beat after a random gap and hold it until accepted
  task automatic send_beat(logic [55:0] beat);
    while (!calm && $urandom_range(99) < 23) @(negedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= beat;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(beat);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // wait until every expected result has come, then let the block settle
  task automatic drain();
    while (sb.pending_views.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic [1:0] mode;
    bit [11:0] px[4];
    mode = 2'($urandom_range(3));
    for (int k = 0; k < 4; k++)
      case ($urandom_range(5))
        0: px[k] = 12'd0;
        1: px[k] = 12'hfff;
        2: px[k] = 12'($urandom);
        default: px[k] = 12'(2048 + $urandom_range(40) - 20);
      endcase
    send_beat(pack_item(mode, px[0], px[1], px[2], px[3], 2'($urandom), 2'($urandom)));
  endtask

  initial begin
    bit [31:0] gains[6];
    bit [31:0] steps[6];
    bit [31:0] sights[6];
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgGain;
    cfg_data_i = '0;
    calm = 1'b0;
    hold_cycles = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset view, rotations with extreme pixels, every move sign and translate axis
    send_beat(pack_item(ModeReport, 0, 0, 0, 0, 2'b00, 2'd0));
    send_beat(pack_item(ModeMove, 0, 0, 0, 0, 2'b01, 2'd0));
    drain();
    write_reg(CfgGain, 32'h00b6_0b61);
    write_reg(CfgStep, 32'd65536);
    write_reg(CfgSight, 32'd262144);
    send_beat(pack_item(ModeRotate, 0, 0, 12'hfff, 12'hfff, 2'b00, 2'd0));
    send_beat(pack_item(ModeRotate, 12'hfff, 12'hfff, 0, 0, 2'b00, 2'd0));
    send_beat(pack_item(ModeRotate, 2048, 2048, 2048, 2048, 2'b00, 2'd0));
    send_beat(pack_item(ModeRotate, 2000, 2100, 2030, 2060, 2'b00, 2'd0));
    send_beat(pack_item(ModeMove, 0, 0, 0, 0, 2'b01, 2'd0));
    send_beat(pack_item(ModeMove, 0, 0, 0, 0, 2'b11, 2'd0));
    send_beat(pack_item(ModeMove, 0, 0, 0, 0, 2'b10, 2'd0));
    send_beat(pack_item(ModeMove, 0, 0, 0, 0, 2'b00, 2'd0));
    for (int a = 0; a < 4; a++) send_beat(pack_item(ModeTranslate, 0, 0, 0, 0, 2'b01, 2'(a)));
    send_beat(pack_item(ModeTranslate, 0, 0, 0, 0, 2'b10, 2'd2));
    send_beat(pack_item(ModeReport, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 2'b11, 2'd3));
    drain();
    // saturate the eye both ways with the largest step and sight
    write_reg(CfgStep, 32'h7fff_ffff);
    write_reg(CfgSight, 32'h7fff_ffff);
    for (int i = 0; i < 2; i++) send_beat(pack_item(ModeTranslate, 0, 0, 0, 0, 2'b01, 2'd0));
    for (int i = 0; i < 3; i++) send_beat(pack_item(ModeTranslate, 0, 0, 0, 0, 2'b10, 2'd0));
    send_beat(pack_item(ModeMove, 0, 0, 0, 0, 2'b10, 2'd0));
    send_beat(pack_item(ModeReport, 0, 0, 0, 0, 2'b00, 2'd0));

    // random phases, each under its own register setting
    gains  = '{32'hffff_ffff, 32'd1, 32'h00b6_0b61, 32'd0, $urandom, $urandom};
    steps  = '{32'd65536, 32'h7fff_ffff, 32'd0, $urandom_range(32'h000f_ffff),
               $urandom_range(32'h7fff_ffff), 32'd6553};
    sights = '{32'd0, 32'd65536, 32'h7fff_ffff, $urandom_range(32'h00ff_ffff),
               $urandom_range(32'h7fff_ffff), 32'd655360};
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(CfgGain, gains[ph]);
      write_reg(CfgStep, steps[ph]);
      write_reg(CfgSight, sights[ph]);
      for (int i = 0; i < 190; i++) begin
        calm = (ph == 1) && (i >= 40) && (i < 140);
        if (ph == 2 && i == 60) hold_cycles = 400;
        if (ph == 3 && i == 90) while (sb.pending_views.size() != 0) @(posedge clk_i);
        send_random();
      end
      calm = 1'b0;
    end

    drain();
    $display("covered %0d beats: %0d rotate, %0d move, %0d translate, %0d report",
             sb.checked, sb.op_count[0], sb.op_count[1], sb.op_count[2], sb.op_count[3]);
    $display("six register settings including zero and full-scale gain, step and sight");
    if (sb.errors == 0 && sb.pending_views.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/ypc_pkg.sv
hw/rtl/ypc_ctrl.sv
hw/rtl/ypc_datapath.sv
hw/rtl/yaw_pitch_camera_update.sv
tb/tb_top.sv
